>>> rtl/core/winding_number_point_in_polygon_defines.svh
// Assertion macros shared by the core modules.
// Each macro expects clk and rst_n in scope.
`ifndef WINDING_NUMBER_POINT_IN_POLYGON_DEFINES_SVH
`define WINDING_NUMBER_POINT_IN_POLYGON_DEFINES_SVH

// Same-cycle implication.
`define WNP_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WNP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/wnp_pkg.sv
`timescale 1ns / 1ps

package wnp_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;

    localparam int OP_BITS = 2;
    localparam logic [OP_BITS-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;

    localparam int WINDING_BITS = 8;
    localparam int WINDING_MAX  = 127;
    localparam int WINDING_MIN  = -128;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_first;
        logic pt_load;
        logic wn_clear;
        logic out_load;
        logic out_query;
        logic out_dropped;
    } wnp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;
        logic out_full;
    } wnp_sts_t;

endpackage

>>> rtl/core/wnp_in_if.sv
`timescale 1ns / 1ps

interface wnp_in_if #(
    parameter int COORD_BITS = wnp_pkg::COORD_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [wnp_pkg::OP_BITS-1:0]       op;
    logic signed [COORD_BITS-1:0]      coord_x;
    logic signed [COORD_BITS-1:0]      coord_y;

    modport source (output valid, op, coord_x, coord_y, input ready);
    modport sink   (input valid, op, coord_x, coord_y, output ready);
endinterface

>>> rtl/core/wnp_out_if.sv
`timescale 1ns / 1ps

interface wnp_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   status;
    logic                                   inside_res;
    logic signed [wnp_pkg::WINDING_BITS-1:0] winding;

    modport source (output valid, status, inside_res, winding, input ready);
    modport sink   (input valid, status, inside_res, winding, output ready);
endinterface

>>> rtl/core/wnp_ctrl.sv
`timescale 1ns / 1ps
`include "winding_number_point_in_polygon_defines.svh"

module wnp_ctrl #(
    parameter int  MAX_VERTICES = wnp_pkg::MAX_VERTICES_DEF,
    localparam int ADDR_W       = $clog2(MAX_VERTICES),
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [wnp_pkg::OP_BITS-1:0]   req_op,
    output wnp_pkg::wnp_cmd_t             cmd,
    output logic [ADDR_W-1:0]             addr,
    input  wnp_pkg::wnp_sts_t             sts
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             dropped_reg, dropped_next;
    logic             query_reg, query_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            dropped_reg <= 1'b0;
            query_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            dropped_reg <= dropped_next;
            query_reg   <= query_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        dropped_next    = dropped_reg;
        query_next      = query_reg;
        cmd             = '0;
        cmd.out_query   = query_reg;
        cmd.out_dropped = dropped_reg;
        addr            = count_reg[ADDR_W-1:0];
        req_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    dropped_next = 1'b0;
                    query_next   = 1'b0;
                    state_next   = ST_FIN;
                    case (req_op)
                        wnp_pkg::OP_APPEND:
                        begin
                            if (count_reg < CNT_MAX)
                            begin
                                cmd.wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        wnp_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        wnp_pkg::OP_QUERY:
                        begin
                            query_next   = 1'b1;
                            cmd.pt_load  = 1'b1;
                            cmd.wn_clear = 1'b1;
                            idx_next     = '0;
                            // empty polygon skips the walk and reports outside
                            if (count_reg != '0)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // walk vertices 0..n-1, then vertex 0 again to close the polygon
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (idx_reg == '0);
                addr         = (idx_reg == count_reg) ? '0 : idx_reg[ADDR_W-1:0];
                idx_next     = idx_reg + CNT_W'(1);
                if (idx_reg == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `WNP_ASSERT(a_count_bound, 1'b1, count_reg <= CNT_MAX, "vertex count above store depth")
    `WNP_ASSERT_NEXT(a_read_to_drain, (state_reg == ST_READ) && (idx_reg == count_reg), state_reg == ST_DRAIN, "walk did not end after closing edge")
    `WNP_ASSERT_NEXT(a_append_count, (state_reg == ST_IDLE) && req_valid && (req_op == wnp_pkg::OP_APPEND) && (count_reg < CNT_MAX), count_reg == $past(count_reg) + CNT_W'(1), "append did not advance vertex count")

endmodule

>>> rtl/core/wnp_datapath.sv
`timescale 1ns / 1ps
`include "winding_number_point_in_polygon_defines.svh"

module wnp_datapath #(
    parameter int  MAX_VERTICES = wnp_pkg::MAX_VERTICES_DEF,
    parameter int  COORD_BITS   = wnp_pkg::COORD_BITS_DEF,
    localparam int ADDR_W       = $clog2(MAX_VERTICES)
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  wnp_pkg::wnp_cmd_t                        cmd,
    input  logic [ADDR_W-1:0]                        addr,
    input  logic signed [COORD_BITS-1:0]             coord_x,
    input  logic signed [COORD_BITS-1:0]             coord_y,
    output wnp_pkg::wnp_sts_t                        sts,
    input  logic                                     rsp_ready,
    output logic                                     rsp_valid,
    output logic                                     status,
    output logic                                     inside_res,
    output logic signed [wnp_pkg::WINDING_BITS-1:0]  winding
);

    localparam int D    = COORD_BITS + 1;
    localparam int P    = 2 * D;
    localparam int WN_W = $clog2(MAX_VERTICES + 1) + 1;
    localparam int WB   = wnp_pkg::WINDING_BITS;
    localparam logic signed [WN_W-1:0] WN_LIM = WN_W'(MAX_VERTICES);

    // vertex store, x in the upper half
    logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] rd_data_reg;

    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic                         rd_v_reg, rd_first_reg;

    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic signed [D-1:0]          dxb, dyp, dxp, dyb;
    logic                         up, dn;

    logic signed [D-1:0] dxb_reg, dyp_reg, dxp_reg, dyb_reg;
    logic                ex_up_reg, ex_dn_reg, ex_v_reg;

    logic signed [P-1:0] p1_reg, p2_reg;
    logic                mul_up_reg, mul_dn_reg, mul_v_reg;

    logic signed [P:0]      cross_val;
    logic signed [WN_W-1:0] wn_reg;
    logic signed [WB-1:0]   wn_sat;

    logic                 out_valid_reg;
    logic                 status_reg;
    logic                 inside_reg;
    logic signed [WB-1:0] winding_reg;
    logic                 out_full;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= {coord_x, coord_y};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            ex_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= cmd.rd_en;
            ex_v_reg  <= rd_v_reg && !rd_first_reg;
            mul_v_reg <= ex_v_reg;
        end
    end

    // stage 1: edge from the previous vertex to the one just read
    assign ax = prev_x_reg;
    assign ay = prev_y_reg;
    assign bx = $signed(rd_data_reg[2*COORD_BITS-1:COORD_BITS]);
    assign by = $signed(rd_data_reg[COORD_BITS-1:0]);

    assign dxb = $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});
    assign dyp = $signed({py_reg[COORD_BITS-1], py_reg}) - $signed({ay[COORD_BITS-1], ay});
    assign dxp = $signed({px_reg[COORD_BITS-1], px_reg}) - $signed({ax[COORD_BITS-1], ax});
    assign dyb = $signed({by[COORD_BITS-1], by}) - $signed({ay[COORD_BITS-1], ay});
    assign up  = (ay <= py_reg) && (by > py_reg);
    assign dn  = (ay > py_reg) && (by <= py_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.pt_load)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        rd_first_reg <= cmd.rd_first;
        if (rd_v_reg)
        begin
            prev_x_reg <= bx;
            prev_y_reg <= by;
        end
        dxb_reg    <= dxb;
        dyp_reg    <= dyp;
        dxp_reg    <= dxp;
        dyb_reg    <= dyb;
        ex_up_reg  <= up;
        ex_dn_reg  <= dn;
        // stage 2: the two cross-product terms
        p1_reg     <= dxb_reg * dyp_reg;
        p2_reg     <= dxp_reg * dyb_reg;
        mul_up_reg <= ex_up_reg;
        mul_dn_reg <= ex_dn_reg;
    end

    // stage 3: sign of the cross product and winding update
    assign cross_val = $signed({p1_reg[P-1], p1_reg}) - $signed({p2_reg[P-1], p2_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wn_reg <= '0;
        end
        else if (cmd.wn_clear)
        begin
            wn_reg <= '0;
        end
        else if (mul_v_reg)
        begin
            if (mul_up_reg && (cross_val > 0))
            begin
                wn_reg <= wn_reg + WN_W'(1);
            end
            else if (mul_dn_reg && (cross_val < 0))
            begin
                wn_reg <= wn_reg - WN_W'(1);
            end
        end
    end

    if (WN_W > WB)
    begin : g_sat
        localparam logic signed [WN_W-1:0] WN_HI = WN_W'(wnp_pkg::WINDING_MAX);
        localparam logic signed [WN_W-1:0] WN_LO = WN_W'(wnp_pkg::WINDING_MIN);
        always_comb
        begin
            if (wn_reg > WN_HI)
            begin
                wn_sat = WB'(wnp_pkg::WINDING_MAX);
            end
            else if (wn_reg < WN_LO)
            begin
                wn_sat = WB'(wnp_pkg::WINDING_MIN);
            end
            else
            begin
                wn_sat = WB'(wn_reg);
            end
        end
    end
    else
    begin : g_ext
        assign wn_sat = WB'(wn_reg);
    end

    assign out_full = out_valid_reg && !rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg  <= cmd.out_dropped;
            inside_reg  <= cmd.out_query && (wn_reg != '0);
            winding_reg <= cmd.out_query ? wn_sat : '0;
        end
    end

    assign sts.pipe_busy = rd_v_reg || ex_v_reg || mul_v_reg;
    assign sts.out_full  = out_full;

    assign rsp_valid  = out_valid_reg;
    assign status     = status_reg;
    assign inside_res = inside_reg;
    assign winding    = winding_reg;

    `WNP_ASSERT(a_load_free, cmd.out_load, !out_full, "result loaded over an untaken transaction")
    `WNP_ASSERT(a_load_idle, cmd.out_load, !sts.pipe_busy, "result loaded while edges still in flight")
    `WNP_ASSERT(a_wn_bound, 1'b1, (wn_reg <= WN_LIM) && (wn_reg >= -WN_LIM), "winding count beyond vertex count")

endmodule

>>> rtl/core/winding_number_point_in_polygon.sv
// Winding-number point-in-polygon test. The block keeps a closed polygon of up to
// MAX_VERTICES signed vertices in a single-port store; each req transaction appends
// a vertex (op 0), clears the polygon (op 1) or queries a point (op 2), and gives
// exactly one rsp transaction. For a query on an n-vertex polygon, the store read
// port delivers one vertex per cycle over n + 1 reads to close the polygon,
// followed by a three-stage difference, multiply and accumulate pipeline that is
// drained before the result is loaded. A query on an empty polygon skips the
// walk and reports outside. A new transaction is accepted while the previous
// result still waits in the output register; the result holds until rsp.ready
// is seen.
`timescale 1ns / 1ps

module winding_number_point_in_polygon #(
    parameter int  MAX_VERTICES = wnp_pkg::MAX_VERTICES_DEF,
    parameter int  COORD_BITS   = wnp_pkg::COORD_BITS_DEF,
    localparam int ADDR_W       = $clog2(MAX_VERTICES)
) (
    input  logic       clk,
    input  logic       rst_n,
    wnp_in_if.sink     req,
    wnp_out_if.source  rsp
);

    wnp_pkg::wnp_cmd_t  cmd;
    wnp_pkg::wnp_sts_t  sts;
    logic [ADDR_W-1:0]  addr;

    wnp_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_op    (req.op),
        .cmd       (cmd),
        .addr      (addr),
        .sts       (sts)
    );

    wnp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .addr       (addr),
        .coord_x    (req.coord_x),
        .coord_y    (req.coord_y),
        .sts        (sts),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .status     (rsp.status),
        .inside_res (rsp.inside_res),
        .winding    (rsp.winding)
    );

endmodule
